FILE: rtl/core/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and the precedence function shared by the
// infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam logic [7:0] CH_CARET  = 8'h5E; // '^'
    localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
    localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
    localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D; // '-'
    localparam logic [7:0] CH_LPAREN = 8'h28; // '('
    localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
    localparam logic [7:0] CH_LO_A   = 8'h61; // 'a'
    localparam logic [7:0] CH_LO_Z   = 8'h7A; // 'z'
    localparam logic [7:0] CH_UP_A   = 8'h41; // 'A'
    localparam logic [7:0] CH_UP_Z   = 8'h5A; // 'Z'

    // Precedence levels; the lowest code stands for "no precedence".
    localparam logic [1:0] RANK_NONE  = 2'd0;
    localparam logic [1:0] RANK_ADD   = 2'd1;
    localparam logic [1:0] RANK_MUL   = 2'd2;
    localparam logic [1:0] RANK_POWER = 2'd3;

    typedef enum logic [1:0] {
        CLS_LETTER,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_OPER
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  ch;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        has_char;
        logic        run_last;
        logic        expr_end;
        logic        overflow;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAIN,
        S_FETCH,
        S_FLUSH,
        S_END
    } state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_TAKE,
        ACT_EMIT,
        ACT_PUSH,
        ACT_OVF,
        ACT_POP,
        ACT_DROP,
        ACT_LOAD,
        ACT_CLOSE
    } action_t;

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        logic [1:0] r;
        begin
            r = RANK_NONE;
            if (c == CH_CARET)
            begin
                r = RANK_POWER;
            end
            else if (c == CH_STAR || c == CH_SLASH)
            begin
                r = RANK_MUL;
            end
            else if (c == CH_PLUS || c == CH_MINUS)
            begin
                r = RANK_ADD;
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/itp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_front
// Accepts input characters, classifies them and holds them in a two-entry
// queue until the stack engine takes them.
// ----------------------------------------------------------------------------
module itp_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     char_in,
    input  logic           is_last,
    output logic           q_valid,
    output itp_pkg::item_t q_item,
    input  logic           q_take
);

    itp_pkg::item_t  slot_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      count_reg, count_next;
    itp_pkg::item_t  item_in;
    logic            do_wr;
    logic            do_rd;

    always_comb
    begin
        item_in.ch   = char_in;
        item_in.last = is_last;
        if ((char_in >= itp_pkg::CH_LO_A && char_in <= itp_pkg::CH_LO_Z) ||
            (char_in >= itp_pkg::CH_UP_A && char_in <= itp_pkg::CH_UP_Z))
        begin
            item_in.cls = itp_pkg::CLS_LETTER;
        end
        else if (char_in == itp_pkg::CH_LPAREN)
        begin
            item_in.cls = itp_pkg::CLS_LPAREN;
        end
        else if (char_in == itp_pkg::CH_RPAREN)
        begin
            item_in.cls = itp_pkg::CLS_RPAREN;
        end
        else
        begin
            item_in.cls = itp_pkg::CLS_OPER;
        end
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];
    assign do_wr   = push && !full;
    assign do_rd   = q_take && q_valid;

    always_comb
    begin
        wptr_next  = do_wr ? ~wptr_reg : wptr_reg;
        rptr_next  = do_rd ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= item_in;
        end
    end

endmodule

FILE: rtl/core/itp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_out_fifo
// Two-entry result queue that parts the stack engine from the receiver.
// ----------------------------------------------------------------------------
module itp_out_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  itp_pkg::result_t wr_data,
    output logic             wr_full,
    output logic             empty,
    input  logic             pop,
    output itp_pkg::result_t rd_data
);

    itp_pkg::result_t slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rptr_reg];
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        wptr_next  = do_wr ? ~wptr_reg : wptr_reg;
        rptr_next  = do_rd ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/itp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_back
// Stack engine: carries out one classified character at a time against the
// operator stack and hands the results on to the result queue.
// ----------------------------------------------------------------------------
module itp_back
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  itp_pkg::item_t   q_item,
    output logic             q_take,
    output logic             of_wr,
    output itp_pkg::result_t of_data,
    input  logic             of_full
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // The top of stack lives in top_reg; the entries below it are in mem.
    logic [7:0]        mem [STACK_DEPTH];
    logic [7:0]        rd_data_reg;

    itp_pkg::state_t   state_reg, state_next;
    itp_pkg::state_t   ret_reg, ret_next;
    itp_pkg::cls_t     cls_reg, cls_next;
    logic [7:0]        ch_reg, ch_next;
    logic              last_reg, last_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [7:0]        top_reg, top_next;
    logic              ovf_seen_reg, ovf_seen_next;
    logic              pend_valid_reg, pend_valid_next;
    itp_pkg::result_t  pend_reg, pend_next;

    itp_pkg::action_t  act;
    itp_pkg::state_t   after;
    itp_pkg::state_t   post;
    logic              stall;
    logic              emit;
    itp_pkg::result_t  emit_res;
    logic              mem_we;
    logic              mem_re;
    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic              top_is_lp;

    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign top_is_lp = (top_reg == itp_pkg::CH_LPAREN);
    assign post      = last_reg ? itp_pkg::S_FLUSH : itp_pkg::S_END;

    // Decoder: what the engine does this cycle and where it goes afterwards.
    always_comb
    begin
        act   = itp_pkg::ACT_NONE;
        after = itp_pkg::S_IDLE;
        unique case (state_reg)
            itp_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    act   = itp_pkg::ACT_TAKE;
                    after = itp_pkg::S_MAIN;
                end
            end
            itp_pkg::S_MAIN:
            begin
                after = post;
                case (cls_reg)
                    itp_pkg::CLS_LETTER:
                    begin
                        act = itp_pkg::ACT_EMIT;
                    end
                    itp_pkg::CLS_LPAREN:
                    begin
                        act = (count_reg < CW'(STACK_DEPTH)) ? itp_pkg::ACT_PUSH
                                                             : itp_pkg::ACT_OVF;
                    end
                    itp_pkg::CLS_RPAREN:
                    begin
                        if (count_reg != '0 && !top_is_lp)
                        begin
                            act   = itp_pkg::ACT_POP;
                            after = itp_pkg::S_MAIN;
                        end
                        else if (count_reg != '0)
                        begin
                            act = itp_pkg::ACT_DROP;
                        end
                    end
                    default:
                    begin
                        if (count_reg != '0 &&
                            itp_pkg::rank_of(top_reg) >= itp_pkg::rank_of(ch_reg))
                        begin
                            act   = itp_pkg::ACT_POP;
                            after = itp_pkg::S_MAIN;
                        end
                        else if (count_reg < CW'(STACK_DEPTH))
                        begin
                            act = itp_pkg::ACT_PUSH;
                        end
                        else
                        begin
                            act = itp_pkg::ACT_OVF;
                        end
                    end
                endcase
            end
            itp_pkg::S_FETCH:
            begin
                act   = itp_pkg::ACT_LOAD;
                after = ret_reg;
            end
            itp_pkg::S_FLUSH:
            begin
                if (count_reg != '0)
                begin
                    act   = itp_pkg::ACT_POP;
                    after = itp_pkg::S_FLUSH;
                end
                else
                begin
                    after = itp_pkg::S_END;
                end
            end
            itp_pkg::S_END:
            begin
                act = itp_pkg::ACT_CLOSE;
            end
            default:
            begin
                act = itp_pkg::ACT_NONE;
            end
        endcase
    end

    // A new result displaces the pending one into the queue, so it must wait
    // for room there.
    always_comb
    begin
        emit  = (act == itp_pkg::ACT_EMIT) || (act == itp_pkg::ACT_OVF) ||
                (act == itp_pkg::ACT_POP);
        stall = (emit && pend_valid_reg && of_full) ||
                (act == itp_pkg::ACT_CLOSE && (pend_valid_reg || last_reg) && of_full);
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        if (!stall)
        begin
            if ((act == itp_pkg::ACT_POP || act == itp_pkg::ACT_DROP) &&
                count_reg > CW'(1))
            begin
                state_next = itp_pkg::S_FETCH;
                ret_next   = after;
            end
            else
            begin
                state_next = after;
            end
        end
    end

    always_comb
    begin
        q_take          = 1'b0;
        of_wr           = 1'b0;
        of_data         = pend_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        cls_next        = cls_reg;
        ch_next         = ch_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        ovf_seen_next   = ovf_seen_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        emit_res          = '0;
        if (act == itp_pkg::ACT_EMIT)
        begin
            emit_res.char_out = ch_reg;
            emit_res.has_char = 1'b1;
        end
        else if (act == itp_pkg::ACT_POP)
        begin
            emit_res.char_out = top_reg;
            emit_res.has_char = 1'b1;
        end
        else
        begin
            emit_res.overflow = 1'b1;
        end

        if (!stall)
        begin
            if (emit)
            begin
                of_wr           = pend_valid_reg;
                pend_next       = emit_res;
                pend_valid_next = 1'b1;
            end
            case (act)
                itp_pkg::ACT_TAKE:
                begin
                    q_take    = 1'b1;
                    cls_next  = q_item.cls;
                    ch_next   = q_item.ch;
                    last_next = q_item.last;
                end
                itp_pkg::ACT_PUSH:
                begin
                    mem_we     = (count_reg != '0);
                    top_next   = ch_reg;
                    count_next = count_reg + CW'(1);
                end
                itp_pkg::ACT_OVF:
                begin
                    ovf_seen_next = 1'b1;
                end
                itp_pkg::ACT_POP, itp_pkg::ACT_DROP:
                begin
                    mem_re     = (count_reg > CW'(1));
                    count_next = cnt_m1;
                end
                itp_pkg::ACT_LOAD:
                begin
                    top_next = rd_data_reg;
                end
                itp_pkg::ACT_CLOSE:
                begin
                    of_data          = pend_reg;
                    of_data.run_last = 1'b1;
                    if (!pend_valid_reg)
                    begin
                        of_data = '0;
                        of_data.run_last = 1'b1;
                    end
                    if (last_reg)
                    begin
                        of_data.expr_end = 1'b1;
                        of_data.overflow = of_data.overflow | ovf_seen_reg;
                        count_next       = '0;
                        ovf_seen_next    = 1'b0;
                    end
                    of_wr           = pend_valid_reg || last_reg;
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itp_pkg::S_IDLE;
            ret_reg        <= itp_pkg::S_IDLE;
            count_reg      <= '0;
            ovf_seen_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            count_reg      <= count_next;
            ovf_seen_reg   <= ovf_seen_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg  <= cls_next;
        ch_reg   <= ch_next;
        last_reg <= last_next;
        top_reg  <= top_next;
        pend_reg <= pend_next;
    end

    // Stack memory: the old top is written below the new one on a push, and
    // the entry under the top is read back on a pop or a dropped bracket.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_m1[AW-1:0]] <= top_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[cnt_m2[AW-1:0]];
        end
    end

endmodule

FILE: rtl/core/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix.
// ----------------------------------------------------------------------------
// Input channel: write a character with push while full is low; is_last marks
// the final character of an expression and flushes the operator stack.
// Result channel: while empty is low the oldest result is on char_out,
// has_char, run_last, expr_end and overflow; pop takes it.
// Timing: the stack engine takes each character from the input queue, works on
// it and closes it, with a flush step more on the last character of an
// expression; each operator popped off the stack adds a pop step, and a fetch
// step when entries lie below it; a dropped opening bracket with entries below
// it adds a fetch step, the stack memory read that brings the next entry up.
// A result is handed to the result queue once the next result of the same
// character exists or the character is finished.
// A two-entry input queue and a two-entry result queue let either side stall
// on its own; when the receiver stops popping the engine waits and the input
// queue fills, after which full is raised.
// Reset clears the stack count, the overflow flag and both queues; the stack
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       is_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] char_out,
    output logic       has_char,
    output logic       run_last,
    output logic       expr_end,
    output logic       overflow
);

    logic             q_valid;
    itp_pkg::item_t   q_item;
    logic             q_take;
    logic             of_wr;
    itp_pkg::result_t of_data;
    logic             of_full;
    itp_pkg::result_t res;

    itp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .char_in (char_in),
        .is_last (is_last),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take)
    );

    itp_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_take  (q_take),
        .of_wr   (of_wr),
        .of_data (of_data),
        .of_full (of_full)
    );

    itp_out_fifo u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (of_wr),
        .wr_data (of_data),
        .wr_full (of_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res)
    );

    assign char_out = res.char_out;
    assign has_char = res.has_char;
    assign run_last = res.run_last;
    assign expr_end = res.expr_end;
    assign overflow = res.overflow;

endmodule

FILE: rtl/core/itp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the result stream of the converter.
// ----------------------------------------------------------------------------
module itp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] char_in,
    input logic       is_last,
    input logic       empty,
    input logic       pop,
    input logic [7:0] char_out,
    input logic       has_char,
    input logic       run_last,
    input logic       expr_end,
    input logic       overflow
);

    // An offered character and its flag must be known, as must the reply.
    a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !$isunknown({full, char_in, is_last}))
        else $error("unknown value on the input channel during push");

    // The end of an expression is always the last result of its character.
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && expr_end) |-> run_last)
        else $error("expr_end without run_last");

    // A result without a character reports either the end or an overflow.
    a_empty_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_char) |-> (overflow || expr_end))
        else $error("result without character and without reason");

    a_no_char_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_char) |-> (char_out == 8'h00))
        else $error("char_out not zero on a result without character");

    // A waiting result that is not taken stays on the ports unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_out) && $stable(has_char) &&
                              $stable(run_last) && $stable(expr_end) &&
                              $stable(overflow)))
        else $error("waiting result changed before transfer");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
